/* rtl/core/imu_serial_frame_sync_parser_assert.svh */
// assertion macros shared by the frame sync parser rtl
// no dependencies; included by the modules that carry checks
`ifndef IMU_SERIAL_FRAME_SYNC_PARSER_ASSERT_SVH
`define IMU_SERIAL_FRAME_SYNC_PARSER_ASSERT_SVH

// condition and consequence in the same cycle
`define ISFSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("isfsp: same-cycle check failed");

// consequence in the cycle after the condition
`define ISFSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("isfsp: next-cycle check failed");

`endif

/* rtl/core/isfsp_pkg.sv */
// types and constants of the serial frame sync parser
// no dependencies
`default_nettype none

package isfsp_pkg;

	localparam int unsigned WINDOW_LEN = 10;
	localparam logic [7:0]  SYNC_RESET = 8'h55;
	localparam logic [7:0]  TYPE_ACCEL = 8'h51;
	localparam logic [7:0]  TYPE_RATE  = 8'h52;
	localparam logic [7:0]  TYPE_QUAT  = 8'h59;
	localparam logic [3:0]  FILL_FULL  = 4'(WINDOW_LEN);

	typedef enum logic [1:0] {
		KIND_ACCEL = 2'd0,
		KIND_RATE  = 2'd1,
		KIND_QUAT  = 2'd2,
		KIND_OTHER = 2'd3
	} frame_kind_t;

	typedef struct packed {
		frame_kind_t        frame_kind;
		logic [7:0]         type_code;
		logic signed [15:0] word_first;
		logic signed [15:0] word_second;
		logic signed [15:0] word_third;
		logic signed [15:0] word_fourth;
	} frame_t;

	typedef struct packed {
		logic hit;
		logic full;
	} win_status_t;

	function automatic frame_kind_t kind_of(input logic [7:0] code);
		frame_kind_t k;
		case (code)
			TYPE_ACCEL: k = KIND_ACCEL;
			TYPE_RATE:  k = KIND_RATE;
			TYPE_QUAT:  k = KIND_QUAT;
			default:    k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/isfsp_ifs.sv */
// stream interfaces of the frame sync parser: received bytes and decoded frames
// no dependencies
`default_nettype none

interface isfsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface isfsp_frame_if;
	logic               valid;
	logic               ready;
	logic [1:0]         frame_kind;
	logic [7:0]         type_code;
	logic signed [15:0] word_first;
	logic signed [15:0] word_second;
	logic signed [15:0] word_third;
	logic signed [15:0] word_fourth;

	modport source (output valid, output frame_kind, output type_code, output word_first,
		output word_second, output word_third, output word_fourth, input ready);
	modport sink   (input valid, input frame_kind, input type_code, input word_first,
		input word_second, input word_third, input word_fourth, output ready);
endinterface

`default_nettype wire

/* rtl/core/isfsp_window.sv */
// ten-byte shift window with fill count, checksum and frame match
// depends on isfsp_pkg and the assertion macro header
`default_nettype none
`include "imu_serial_frame_sync_parser_assert.svh"

module isfsp_window
	import isfsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  sync_value,
	output win_status_t      status,
	output frame_t           frame
);

	logic [7:0] win_q [WINDOW_LEN];
	logic [3:0] fill_q;
	logic [7:0] pair [WINDOW_LEN/2];
	logic [7:0] quad0, quad1, sum;
	logic       full;
	logic       hit;

	// newest byte enters at the top, so a full window holds the oldest byte at 0
	always_comb begin
		for (int i = 0; i < WINDOW_LEN/2; i++) begin
			pair[i] = win_q[2*i] + win_q[2*i+1];
		end
		quad0 = pair[0] + pair[1];
		quad1 = pair[2] + pair[3];
		sum   = quad0 + quad1 + pair[4];
	end

	assign full = (fill_q == FILL_FULL);
	assign hit  = full && (win_q[0] == sync_value) && (sum == rx_byte);

	assign status.hit  = hit;
	assign status.full = full;

	assign frame.frame_kind  = kind_of(win_q[1]);
	assign frame.type_code   = win_q[1];
	assign frame.word_first  = {win_q[3], win_q[2]};
	assign frame.word_second = {win_q[5], win_q[4]};
	assign frame.word_third  = {win_q[7], win_q[6]};
	assign frame.word_fourth = {win_q[9], win_q[8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (take) begin
			if (hit) begin
				fill_q <= '0;
			end else if (!full) begin
				fill_q <= fill_q + 4'd1;
			end
		end
	end

	// the window is left alone on a match, its bytes are dead once fill clears
	always_ff @(posedge clk) begin
		if (take && !hit) begin
			for (int i = 0; i < WINDOW_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WINDOW_LEN-1] <= rx_byte;
		end
	end

	`ISFSP_ASSERT_NOW(a_fill_range, clk, arst_n, 1'b1, fill_q <= FILL_FULL)
	`ISFSP_ASSERT_NEXT(a_hit_clears, clk, arst_n, take && hit, fill_q == 4'd0)
	`ISFSP_ASSERT_NEXT(a_fill_step, clk, arst_n, take && !full, fill_q == $past(fill_q) + 4'd1)

endmodule

`default_nettype wire

/* rtl/core/imu_serial_frame_sync_parser.sv */
// top level of the serial frame sync parser: config register and result register
// depends on isfsp_pkg, isfsp_ifs, isfsp_window and the assertion macro header
//
//  channel   dir  handshake         payload
//  rx        in   valid/ready       rx_byte
//  frame     out  valid/ready       frame_kind, type_code, word_first..word_fourth
//  cfg       in   cfg_wr_en only    cfg_wr_data -> sync_value
//
// a byte is taken every cycle while rx.ready is high; match and checksum are decided
// in the cycle the byte arrives and the result register shows the frame next cycle.
// reset empties the window and sets the sync byte to 0x55; no clearing pass.
// a waiting frame stalls rx only while frame.ready is low; the window has no
// separate skid, so rx.ready follows the result register alone.
`default_nettype none
`include "imu_serial_frame_sync_parser_assert.svh"

module imu_serial_frame_sync_parser
	import isfsp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	isfsp_byte_if.sink      rx,
	isfsp_frame_if.source   frame
);

	logic [7:0]  sync_q;
	logic        out_valid_q;
	frame_t      res_q;
	win_status_t win_st;
	frame_t      win_frame;
	logic        take;
	logic        out_take;

	assign rx.ready = !out_valid_q || frame.ready;
	assign take     = rx.valid && rx.ready;
	assign out_take = out_valid_q && frame.ready;

	isfsp_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx.rx_byte),
		.sync_value (sync_q),
		.status     (win_st),
		.frame      (win_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_wr_en) begin
			sync_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && win_st.hit) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && win_st.hit) begin
			res_q <= win_frame;
		end
	end

	assign frame.valid       = out_valid_q;
	assign frame.frame_kind  = res_q.frame_kind;
	assign frame.type_code   = res_q.type_code;
	assign frame.word_first  = res_q.word_first;
	assign frame.word_second = res_q.word_second;
	assign frame.word_third  = res_q.word_third;
	assign frame.word_fourth = res_q.word_fourth;

	`ISFSP_ASSERT_NEXT(a_hit_shows, clk, arst_n, take && win_st.hit, out_valid_q)
	`ISFSP_ASSERT_NOW(a_stall_cause, clk, arst_n, !rx.ready, out_valid_q && !frame.ready)
	`ISFSP_ASSERT_NEXT(a_drain, clk, arst_n, out_take && !(take && win_st.hit), !out_valid_q)
	`ISFSP_ASSERT_NOW(a_hit_full, clk, arst_n, win_st.hit, win_st.full)

endmodule

`default_nettype wire
